>>> rtl/irpn_pkg.sv
// ----------------------------------------------------------------------------
// irpn_pkg: shared types and codes of the postfix integer evaluator
// Command and status codes, controller/datapath command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none
package irpn_pkg;

    typedef enum logic [3:0] {
        CMD_PUSH   = 4'd0,
        CMD_PUSHM  = 4'd1,
        CMD_INV    = 4'd2,
        CMD_FACT   = 4'd3,
        CMD_COMB   = 4'd4,
        CMD_SQRT   = 4'd5,
        CMD_POW    = 4'd6,
        CMD_MAX    = 4'd7,
        CMD_MIN    = 4'd8,
        CMD_ADD    = 4'd9,
        CMD_SUB    = 4'd10,
        CMD_MUL    = 4'd11,
        CMD_DIV    = 4'd12,
        CMD_END    = 4'd13,
        CMD_WRM    = 4'd14,
        CMD_NOP    = 4'd15
    } cmd_t;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_UNDER  = 3'd1;
    localparam logic [2:0] ST_OVER   = 3'd2;
    localparam logic [2:0] ST_DIVZ   = 3'd3;
    localparam logic [2:0] ST_DOMAIN = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request fields
        logic rd_b;      // issue stack read of top entry
        logic rd_a;      // issue stack read of entry below top
        logic cap_b;     // capture read data as b
        logic cap_a;     // capture read data as a
        logic start;     // start arithmetic unit
        logic wr_res;    // write result, adjust pointer
        logic emit;      // drive result register
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic busy;      // arithmetic unit running
        logic out_full;  // result register occupied
    } sts_t;

endpackage
`default_nettype wire

>>> rtl/irpn_if.sv
// ----------------------------------------------------------------------------
// irpn_req_if / irpn_rsp_if: valid/ready channels
// Request carries one instruction; response carries value and status.
// ----------------------------------------------------------------------------
`default_nettype none
interface irpn_req_if;
    logic               valid;
    logic               ready;
    logic        [3:0]  command;
    logic signed [31:0] operand;
    logic        [7:0]  place;
    modport source (output valid, command, operand, place, input ready);
    modport sink   (input valid, command, operand, place, output ready);
endinterface

interface irpn_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic        [2:0]  status;
    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface
`default_nettype wire

>>> rtl/irpn_ctrl.sv
// ----------------------------------------------------------------------------
// irpn_ctrl: instruction sequencer
// Steps each request through reads, optional compute, and write-back or emit.
// ----------------------------------------------------------------------------
`default_nettype none
module irpn_ctrl
    import irpn_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire logic need_b,   // instruction reads the top entry
    input  wire logic need_a,   // instruction reads the second entry
    input  wire logic is_end,
    input  wire logic ok_go,    // no underflow: proceed to arithmetic
    input  wire sts_t sts,
    output ctl_t      ctl
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RDB  = 7'b0000010,
        S_RDA  = 7'b0000100,
        S_CAP  = 7'b0001000,
        S_RUN  = 7'b0010000,
        S_WAIT = 7'b0100000,
        S_WR   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign req_ready = (state_reg == S_IDLE) && !sts.out_full;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_RDB;
                end
            end
            S_RDB:
            begin
                ctl.rd_b   = 1'b1;
                state_next = S_RDA;
            end
            S_RDA:
            begin
                ctl.rd_a   = 1'b1;
                ctl.cap_b  = 1'b1;
                state_next = S_CAP;
            end
            S_CAP:
            begin
                ctl.cap_a = 1'b1;
                if (is_end)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (ok_go && (need_a || need_b))
                begin
                    state_next = S_RUN;
                end
                else
                begin
                    ctl.wr_res = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RUN:
            begin
                ctl.start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (!sts.busy)
                    state_next = S_WR;
            end
            S_WR:
            begin
                ctl.wr_res = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> state_reg == S_RDB) else $error("load did not advance");
    a_wait_start: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |=> state_reg == S_WAIT) else $error("start lost");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sts.busy |-> !req_ready) else $error("accept while busy");
`endif
endmodule
`default_nettype wire

>>> rtl/irpn_alu.sv
// ----------------------------------------------------------------------------
// irpn_alu: multi-cycle arithmetic unit
// A product multiplier shared by fact, comb and mul, separate multipliers for
// pow, one restoring divider for div and comb, and a digit-serial root for sqrt.
// ----------------------------------------------------------------------------
`default_nettype none
module irpn_alu
    import irpn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [3:0]  cmd,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic             busy,
    output logic [31:0]      res,
    output logic [2:0]       err
);
    typedef enum logic [8:0] {
        A_IDLE = 9'b000000001,
        A_PRD  = 9'b000000010,   // range product p1 = lo1..hi1
        A_PRD2 = 9'b000000100,   // range product p2 = lo2..hi2
        A_DIV  = 9'b000001000,
        A_DFIN = 9'b000010000,
        A_POW  = 9'b000100000,
        A_SQRT = 9'b001000000,
        A_MUL  = 9'b010000000,
        A_DONE = 9'b100000000
    } ast_t;

    ast_t        st_reg;
    logic [31:0] acc_reg;
    logic [32:0] i_reg;        // signed current factor
    logic [32:0] hi_reg, lo2_reg, hi2_reg;
    logic [31:0] base_reg, e_reg;
    logic [31:0] dn_reg, dd_reg, q_reg;
    logic [32:0] rem_reg;
    logic        qneg_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] r_reg, bit_reg, v_reg;
    logic [2:0]  err_reg;
    logic        is_comb_reg;

    logic signed [32:0] sa, sb, half_a;
    logic [32:0] c_lo1, c_hi1, c_lo2, c_hi2;
    logic [63:0] mprod;
    logic [31:0] absn, absd;
    logic [32:0] rsh;
    logic [31:0] rb;

    assign sa     = {a[31], a};
    assign sb     = {b[31], b};
    assign half_a = (sa < 0) ? -((-sa) >>> 1) : (sa >>> 1);
    assign busy   = (st_reg != A_IDLE);
    assign res    = acc_reg;
    assign err    = err_reg;

    always_comb
    begin
        if (sb <= half_a)
        begin
            // negative b gives an empty numerator range; a+1 keeps it in 33 bits
            c_lo1 = sb[32] ? (sa + 33'sd1) : (sa - sb + 33'sd1); c_hi1 = sa;
            c_lo2 = 33'sd1;           c_hi2 = sb;
        end
        else
        begin
            c_lo1 = sb + 33'sd1;      c_hi1 = sa;
            c_lo2 = 33'sd1;           c_hi2 = sa - sb;
        end
    end

    // empty range -> 1, straddles zero -> 0, 34 or more factors -> 0
    function automatic logic [1:0] rp_kind(logic [32:0] lo, logic [32:0] hi);
        logic signed [34:0] span;
        span = $signed({{2{hi[32]}}, hi}) - $signed({{2{lo[32]}}, lo});
        if ($signed(hi) < $signed(lo))               return 2'd1;
        if ($signed(lo) <= 0 && $signed(hi) >= 0)    return 2'd2;
        if (span >= 35'sd33)                         return 2'd2;
        return 2'd0;
    endfunction

    assign mprod = acc_reg * i_reg[31:0];
    assign absn  = dn_reg[31] ? -dn_reg : dn_reg;
    assign absd  = dd_reg[31] ? -dd_reg : dd_reg;
    assign rsh   = {rem_reg[31:0], q_reg[31]};
    assign rb    = r_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= A_IDLE;
        end
        else
        begin
            case (st_reg)
                A_IDLE:
                begin
                    if (start)
                    begin
                        err_reg     <= ST_OK;
                        is_comb_reg <= 1'b0;
                        acc_reg     <= 32'd1;
                        case (cmd)
                            CMD_INV:
                            begin
                                if (b == 32'd0) err_reg <= ST_DIVZ;
                                acc_reg <= (b == 32'd1 || b == 32'hFFFF_FFFF) ? b : 32'd0;
                                st_reg  <= A_DONE;
                            end
                            CMD_FACT:
                            begin
                                i_reg  <= 33'sd2;
                                hi_reg <= sb;
                                st_reg <= A_PRD;
                                if (rp_kind(33'sd2, sb) == 2'd2) acc_reg <= 32'd0;
                                if (rp_kind(33'sd2, sb) != 2'd0) st_reg <= A_DONE;
                            end
                            CMD_COMB:
                            begin
                                if (b == 32'd0)
                                    st_reg <= A_DONE;
                                else
                                begin
                                    is_comb_reg <= 1'b1;
                                    lo2_reg <= c_lo2; hi2_reg <= c_hi2;
                                    i_reg   <= c_lo1; hi_reg  <= c_hi1;
                                    if (rp_kind(c_lo1, c_hi1) == 2'd2) acc_reg <= 32'd0;
                                    st_reg  <= (rp_kind(c_lo1, c_hi1) == 2'd0) ? A_PRD : A_PRD2;
                                end
                            end
                            CMD_SQRT:
                            begin
                                if (b[31])
                                begin
                                    err_reg <= ST_DOMAIN;
                                    acc_reg <= 32'd0;
                                    st_reg  <= A_DONE;
                                end
                                else
                                begin
                                    v_reg   <= b;
                                    r_reg   <= 32'd0;
                                    bit_reg <= 32'h4000_0000;
                                    st_reg  <= A_SQRT;
                                end
                            end
                            CMD_POW:
                            begin
                                if (b[31])
                                begin
                                    st_reg <= A_DONE;
                                    if (a == 32'd0)
                                    begin
                                        err_reg <= ST_DIVZ; acc_reg <= 32'd0;
                                    end
                                    else if (a == 32'd1)
                                        acc_reg <= 32'd1;
                                    else if (a == 32'hFFFF_FFFF)
                                        acc_reg <= b[0] ? a : 32'd1;
                                    else
                                        acc_reg <= 32'd0;
                                end
                                else
                                begin
                                    base_reg <= a; e_reg <= b; cnt_reg <= '0;
                                    st_reg   <= A_POW;
                                end
                            end
                            CMD_MAX:
                            begin
                                acc_reg <= (sa >= sb) ? a : b; st_reg <= A_DONE;
                            end
                            CMD_MIN:
                            begin
                                acc_reg <= (sa <= sb) ? a : b; st_reg <= A_DONE;
                            end
                            CMD_ADD: begin acc_reg <= a + b; st_reg <= A_DONE; end
                            CMD_SUB: begin acc_reg <= a - b; st_reg <= A_DONE; end
                            CMD_MUL:
                            begin
                                acc_reg <= a; i_reg <= {1'b0, b}; st_reg <= A_MUL;
                            end
                            CMD_DIV:
                            begin
                                dn_reg <= a; dd_reg <= b; st_reg <= A_DIV;
                                cnt_reg <= '0;
                            end
                            default: st_reg <= A_DONE;
                        endcase
                    end
                end
                A_MUL:
                begin
                    acc_reg <= mprod[31:0];
                    st_reg  <= A_DONE;
                end
                A_PRD:
                begin
                    acc_reg <= mprod[31:0];
                    if (i_reg == hi_reg)
                    begin
                        if (is_comb_reg)
                            st_reg <= A_PRD2;
                        else if (cmd == CMD_COMB)
                        begin
                            // comb denominator done; divide
                            dd_reg <= mprod[31:0];
                            st_reg <= A_DIV;
                        end
                        else
                            st_reg <= A_DONE;
                    end
                    else
                        i_reg <= i_reg + 33'd1;
                end
                A_PRD2:
                begin
                    // numerator done; start denominator product
                    acc_reg <= (rp_kind(lo2_reg, hi2_reg) == 2'd2) ? 32'd0 : 32'd1;
                    i_reg   <= lo2_reg; hi_reg <= hi2_reg;
                    is_comb_reg <= 1'b0;
                    dn_reg  <= acc_reg;
                    cnt_reg <= '0;
                    st_reg  <= (rp_kind(lo2_reg, hi2_reg) == 2'd0) ? A_PRD : A_DIV;
                    if (rp_kind(lo2_reg, hi2_reg) != 2'd0)
                    begin
                        dd_reg <= (rp_kind(lo2_reg, hi2_reg) == 2'd2) ? 32'd0 : 32'd1;
                    end
                end
                A_DIV:
                begin
                    // setup; comb reaches here after its denominator product
                    if (dd_reg == 32'd0)
                    begin
                        err_reg <= ST_DIVZ; acc_reg <= 32'd0; st_reg <= A_DONE;
                    end
                    else
                    begin
                        q_reg    <= absn;
                        rem_reg  <= '0;
                        qneg_reg <= dn_reg[31] ^ dd_reg[31];
                        cnt_reg  <= 6'd32;
                        st_reg   <= A_DFIN;
                    end
                end
                A_DFIN:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        acc_reg <= qneg_reg ? -q_reg : q_reg;
                        st_reg  <= A_DONE;
                    end
                    else
                    begin
                        if (rsh >= {1'b0, absd})
                        begin
                            rem_reg <= rsh - {1'b0, absd};
                            q_reg   <= {q_reg[30:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rsh;
                            q_reg   <= {q_reg[30:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                A_POW:
                begin
                    // alternate: multiply step then square step
                    if (cnt_reg[0] == 1'b0)
                    begin
                        if (e_reg == 32'd0)
                            st_reg <= A_DONE;
                        else if (e_reg[0])
                            acc_reg <= acc_reg * base_reg;
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                    else
                    begin
                        base_reg <= base_reg * base_reg;
                        e_reg    <= e_reg >> 1;
                        cnt_reg  <= cnt_reg + 6'd1;
                    end
                end
                A_SQRT:
                begin
                    if (bit_reg == 32'd0)
                    begin
                        acc_reg <= r_reg;
                        st_reg  <= A_DONE;
                    end
                    else
                    begin
                        if (v_reg >= rb)
                        begin
                            v_reg <= v_reg - rb;
                            r_reg <= (r_reg >> 1) + bit_reg;
                        end
                        else
                            r_reg <= r_reg >> 1;
                        bit_reg <= bit_reg >> 2;
                    end
                end
                A_DONE: st_reg <= A_IDLE;
                default: st_reg <= A_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == A_DONE |=> st_reg == A_IDLE) else $error("done stuck");
    a_sqrt_ok: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == A_SQRT |-> err_reg == ST_OK) else $error("sqrt err");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> st_reg == A_IDLE) else $error("start while busy");
`endif
endmodule
`default_nettype wire

>>> rtl/irpn_dp.sv
// ----------------------------------------------------------------------------
// irpn_dp: evaluator datapath
// Operand stack memory, marking memory, pointer, error latch, result reg.
// ----------------------------------------------------------------------------
`default_nettype none
module irpn_dp
    import irpn_pkg::*;
#(
    parameter int STACK_DEPTH = 128,
    parameter int PLACES      = 256
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [3:0]  in_command,
    input  wire logic [31:0] in_operand,
    input  wire logic [7:0]  in_place,
    input  wire ctl_t        ctl,
    output sts_t             sts,
    output logic             need_b,
    output logic             need_a,
    output logic             is_end,
    output logic             ok_go,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      out_value,
    output logic [2:0]       out_status
);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int PW  = (PLACES > 1) ? $clog2(PLACES) : 1;
    localparam int MW  = ((PW > 8) ? PW : 8) + 1;

    logic [31:0]    stk_mem [STACK_DEPTH];
    logic [31:0]    mrk_mem [PLACES];
    logic [PLACES-1:0] mrk_vld_reg;
    logic [SPW-1:0] sp_reg;
    logic [2:0]     ferr_reg;
    logic [3:0]     cmd_reg;
    logic [31:0]    opnd_reg, rd_reg, a_reg, b_reg, mrk_rd_reg;
    logic           mrk_ok_reg;
    logic [MW-1:0]  place_w;
    logic           place_ok;
    logic           unary_c, binary_c;
    logic           alu_busy;
    logic [31:0]    alu_res;
    logic [2:0]     alu_err;
    logic [SPW-1:0] rd_idx;

    assign place_w  = MW'(in_place);
    assign place_ok = place_w < MW'(PLACES);

    assign unary_c  = (cmd_reg == CMD_INV) || (cmd_reg == CMD_FACT) || (cmd_reg == CMD_SQRT);
    assign binary_c = (cmd_reg inside {CMD_COMB, CMD_POW, CMD_MAX, CMD_MIN, CMD_ADD,
                                       CMD_SUB, CMD_MUL, CMD_DIV});
    assign need_b   = unary_c || binary_c;
    assign need_a   = binary_c;
    assign is_end   = (cmd_reg == CMD_END);
    assign ok_go    = binary_c ? (sp_reg >= SPW'(2)) : (sp_reg >= SPW'(1));
    assign sts.busy     = alu_busy;
    assign sts.out_full = out_valid;

    irpn_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.start),
        .cmd   (cmd_reg),
        .a     (a_reg),
        .b     (b_reg),
        .busy  (alu_busy),
        .res   (alu_res),
        .err   (alu_err)
    );

    assign rd_idx = ctl.rd_a ? (sp_reg - SPW'(2)) : (sp_reg - SPW'(1));

    // stack memory: one read port, one write port
    always_ff @(posedge clk)
    begin
        if (ctl.rd_a || ctl.rd_b)
            rd_reg <= stk_mem[rd_idx[SAW-1:0]];
        if (ctl.wr_res)
        begin
            if ((cmd_reg == CMD_PUSH) || (cmd_reg == CMD_PUSHM))
            begin
                // full stack: the pushed value is dropped
                if (sp_reg < SPW'(STACK_DEPTH))
                    stk_mem[sp_reg[SAW-1:0]] <= (cmd_reg == CMD_PUSH) ? opnd_reg
                                                : (mrk_ok_reg ? mrk_rd_reg : 32'd0);
            end
            else if (ok_go && unary_c)
                stk_mem[rd_idx[SAW-1:0]] <= alu_res;
            else if (ok_go && binary_c)
                stk_mem[SAW'(sp_reg - SPW'(2))] <= alu_res;
        end
        if (ctl.load)
        begin
            cmd_reg  <= in_command;
            opnd_reg <= in_operand;
            if (place_ok)
                mrk_rd_reg <= mrk_mem[place_w[PW-1:0]];
            if (in_command == CMD_WRM && place_ok)
                mrk_mem[place_w[PW-1:0]] <= in_operand;
        end
        if (ctl.cap_b)
            b_reg <= rd_reg;
        if (ctl.cap_a)
            a_reg <= (need_a) ? rd_reg : a_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg      <= '0;
            ferr_reg    <= ST_OK;
            out_valid   <= 1'b0;
            out_value   <= '0;
            out_status  <= ST_OK;
            mrk_vld_reg <= '0;
            mrk_ok_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            if (ctl.load)
            begin
                mrk_ok_reg <= place_ok && mrk_vld_reg[place_w[PW-1:0]];
                if (in_command == CMD_WRM && place_ok)
                    mrk_vld_reg[place_w[PW-1:0]] <= 1'b1;
            end
            if (ctl.emit)
            begin
                out_valid  <= 1'b1;
                out_value  <= (sp_reg == '0) ? 32'd0 : b_reg;
                out_status <= (sp_reg == '0 && ferr_reg == ST_OK) ? ST_UNDER : ferr_reg;
                sp_reg     <= '0;
                ferr_reg   <= ST_OK;
            end
            if (ctl.wr_res)
            begin
                if ((cmd_reg == CMD_PUSH) || (cmd_reg == CMD_PUSHM))
                begin
                    if (sp_reg >= SPW'(STACK_DEPTH))
                    begin
                        if (ferr_reg == ST_OK) ferr_reg <= ST_OVER;
                    end
                    else
                        sp_reg <= sp_reg + SPW'(1);
                end
                else if (need_b)
                begin
                    if (!ok_go)
                    begin
                        if (ferr_reg == ST_OK) ferr_reg <= ST_UNDER;
                    end
                    else
                    begin
                        if (ferr_reg == ST_OK) ferr_reg <= alu_err;
                        if (binary_c) sp_reg <= sp_reg - SPW'(1);
                    end
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(STACK_DEPTH)) else $error("pointer out of range");
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |=> sp_reg == '0 && ferr_reg == ST_OK) else $error("end no clear");
    a_emit_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> !out_valid) else $error("result overwritten");
`endif
endmodule
`default_nettype wire

>>> rtl/integer_rpn_expression_evaluator_unit.sv
// ----------------------------------------------------------------------------
// integer_rpn_expression_evaluator_unit: postfix integer evaluator top
// Push, write marking, end and underflowed ops skip the arithmetic unit; the
// others run on the shared arithmetic unit after their operands are read in
// turn through the one stack read port.
// Throughput: one request at a time; a waiting result holds off requests.
// Reset empties the stack, clears the error latch and marks all markings
// zero at once (valid bits).
// ----------------------------------------------------------------------------
`default_nettype none
module integer_rpn_expression_evaluator_unit
    import irpn_pkg::*;
#(
    parameter int STACK_DEPTH = 128,
    parameter int PLACES      = 256
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    irpn_req_if.sink   req,
    irpn_rsp_if.source rsp
);
    ctl_t ctl;
    sts_t sts;
    logic need_b, need_a, is_end, ok_go;

    // sequencer: accept, read operands, run unit, write back
    irpn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .need_b    (need_b),
        .need_a    (need_a),
        .is_end    (is_end),
        .ok_go     (ok_go),
        .sts       (sts),
        .ctl       (ctl)
    );

    // datapath: stack, markings, arithmetic unit, result register
    irpn_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .PLACES      (PLACES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_command (req.command),
        .in_operand (req.operand),
        .in_place   (req.place),
        .ctl        (ctl),
        .sts        (sts),
        .need_b     (need_b),
        .need_a     (need_a),
        .is_end     (is_end),
        .ok_go      (ok_go),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_value  (rsp.value),
        .out_status (rsp.status)
    );

`ifndef SYNTHESIS
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.status <= ST_DOMAIN) else $error("bad status");
    a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready) else $error("double accept");
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("response dropped");
`endif
endmodule
`default_nettype wire
